/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// assertion macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define CHK_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

/* hdl/kwlex_pkg.sv */
// ----------------------------------------------------------------------------
// kwlex_pkg
// types and constants shared by the lexer modules
// ----------------------------------------------------------------------------
package kwlex_pkg;
   localparam int MAX_TEXT_DEF = 8;
   localparam logic [15:0] LIMIT_RESET = 16'd32767;
   localparam logic [16:0] ACC_SAT = 17'd65536;

   typedef enum logic [2:0] {
      KIND_END = 3'd0, KIND_IDENT = 3'd1, KIND_NUMBER = 3'd2, KIND_KEYWORD = 3'd3,
      KIND_OPER = 3'd4, KIND_SEP = 3'd5, KIND_ERROR = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NAME, MODE_NUM, MODE_LT, MODE_GT, MODE_COLON
   } mode_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] text;
      logic [3:0]  len;
      logic [15:0] value;
      logic [15:0] line;
      logic        last;
   } token_type;

   // one front-end item: up to two tokens
   typedef struct packed {
      logic      two;
      token_type t0;
      token_type t1;
   } pair_type;
endpackage

/* hdl/keyword_lexer.sv */
// ----------------------------------------------------------------------------
// keyword_lexer
// streaming tokenizer: one character in, up to two tokens out
// ----------------------------------------------------------------------------
// channel  direction  handshake     payload
// req      in         push / full   char_code
// rsp      out        empty / pop   token fields, last_of_run
// csr      in         csr_wr_en     number limit
// one character accepted per cycle while the queue is not full; the scan state updates in the same cycle
// a double-token character takes an extra pop at the token queue
// the two-entry queue decouples scanning from the consumer; full stalls push
// synchronous reset: idle mode, empty buffers, line 1, limit 32767
`include "assert_macros.svh"
module keyword_lexer #(
   parameter int MAX_TEXT = kwlex_pkg::MAX_TEXT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_char_code,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_token_kind,
   output logic [63:0] rsp_token_text,
   output logic [3:0]  rsp_text_length,
   output logic [15:0] rsp_number_value,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last_of_run,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import kwlex_pkg::*;

   logic [15:0] limit_ff;
   logic step, emit;
   pair_type pair;
   token_type tok;

   // accept when the queue has room
   assign step = push && !full;

   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (csr_wr_en) limit_ff <= csr_wr_data;
   end

   kwlex_front #(.MAX_TEXT(MAX_TEXT)) u_front (
      .clock, .reset, .step, .char_code(req_char_code), .limit(limit_ff),
      .emit, .pair
   );

   kwlex_back u_back (
      .clock, .reset, .wr(emit), .wdata(pair), .full, .empty, .pop, .tok
   );

   assign rsp_token_kind = tok.kind;
   assign rsp_token_text = tok.text;
   assign rsp_text_length = tok.len;
   assign rsp_number_value = tok.value;
   assign rsp_line_number = tok.line;
   assign rsp_last_of_run = tok.last;

   // checks
   `CHK_IMPL(a_len, clock, reset, !empty, rsp_text_length <= 4'd8)
   `CHK_IMPL(a_num_kind, clock, reset, !empty && rsp_number_value != 16'd0, rsp_token_kind == KIND_NUMBER)
   `CHK_NEXT(a_fill, clock, reset, step && emit, !empty)
endmodule

/* hdl/kwlex_front.sv */
// ----------------------------------------------------------------------------
// kwlex_front
// scan state and token classification, up to two tokens per character
// ----------------------------------------------------------------------------
module kwlex_front #(
   parameter int MAX_TEXT = kwlex_pkg::MAX_TEXT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          char_code,
   input  logic [15:0]         limit,
   output logic                emit,
   output kwlex_pkg::pair_type pair
);
   import kwlex_pkg::*;

   localparam int CW = $clog2(MAX_TEXT + 2);

   mode_type        mode_ff, mode_in;
   logic [63:0]     buf_ff, buf_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [16:0]     acc_ff, acc_in;
   logic [15:0]     line_ff, line_in;

   logic [7:0] c;
   logic letter, digit, handle;
   logic [20:0] prod;
   logic [3:0] dval;
   logic [CW-1:0] nlen;
   logic kw;
   token_type pend, own;
   logic pend_v, own_v;

   function automatic token_type mk(input logic [2:0] k, input logic [63:0] t,
                                    input logic [3:0] l, input logic [15:0] v,
                                    input logic [15:0] ln);
      token_type r;
      r.kind = k; r.text = t; r.len = l; r.value = v; r.line = ln; r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      c = char_code;
      letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
      digit = c >= 8'h30 && c <= 8'h39;
      dval = c[3:0];
      prod = {4'd0, acc_ff} * 21'd10 + {17'd0, dval};
      nlen = (cnt_ff > CW'(MAX_TEXT)) ? CW'(MAX_TEXT) : cnt_ff;
      kw = 1'b0;
      if (cnt_ff <= CW'(MAX_TEXT)) begin
         kw = (nlen == CW'(5) && buf_ff[39:0] == 40'h6e69676562)
            || (nlen == CW'(2) && buf_ff[15:0] == 16'h6669)
            || (nlen == CW'(4) && buf_ff[31:0] == 32'h6e656874)
            || (nlen == CW'(5) && buf_ff[39:0] == 40'h656c696877)
            || (nlen == CW'(2) && buf_ff[15:0] == 16'h6f64)
            || (nlen == CW'(3) && buf_ff[23:0] == 24'h646e65);
      end
      mode_in = mode_ff; buf_in = buf_ff; cnt_in = cnt_ff; acc_in = acc_ff;
      line_in = line_ff;
      pend_v = 1'b0; handle = 1'b1;
      pend = mk(KIND_END, 64'd0, 4'd0, 16'd0, line_ff);
      unique case (mode_ff)
         MODE_NAME: begin
            if (letter || digit) begin
               handle = 1'b0;
               if (cnt_ff < CW'(MAX_TEXT)) begin
                  buf_in = buf_ff | ({56'd0, c} << {cnt_ff, 3'b000});
                  cnt_in = cnt_ff + CW'(1);
               end else cnt_in = CW'(MAX_TEXT + 1);
            end else begin
               pend_v = 1'b1;
               pend = mk(kw ? KIND_KEYWORD : KIND_IDENT, buf_ff, 4'(nlen), 16'd0, line_ff);
            end
         end
         MODE_NUM: begin
            if (digit) begin
               handle = 1'b0;
               acc_in = (prod > {4'd0, ACC_SAT}) ? ACC_SAT : prod[16:0];
            end else begin
               pend_v = 1'b1;
               if (acc_ff > {1'b0, limit}) pend = mk(KIND_ERROR, 64'd0, 4'd0, 16'd0, line_ff);
               else pend = mk(KIND_NUMBER, 64'd0, 4'd0, acc_ff[15:0], line_ff);
            end
         end
         MODE_LT, MODE_GT, MODE_COLON: begin
            pend_v = 1'b1;
            if (c == 8'h3d || (mode_ff == MODE_LT && c == 8'h3e)) begin
               handle = 1'b0;
               mode_in = MODE_IDLE;
               pend = mk(KIND_OPER, buf_ff | {48'd0, c, 8'd0}, 4'd2, 16'd0, line_ff);
            end else pend = mk(KIND_OPER, buf_ff, 4'd1, 16'd0, line_ff);
         end
         default: ;
      endcase
      own_v = 1'b0;
      own = mk(KIND_ERROR, {56'd0, c}, 4'd1, 16'd0, line_ff);
      if (handle) begin
         mode_in = MODE_IDLE; buf_in = 64'd0; cnt_in = '0; acc_in = 17'd0;
         if (letter) begin
            mode_in = MODE_NAME; buf_in = {56'd0, c}; cnt_in = CW'(1);
         end else if (digit) begin
            mode_in = MODE_NUM; acc_in = {13'd0, dval};
         end else begin
            case (c)
               8'h3c: begin mode_in = MODE_LT; buf_in = {56'd0, c}; cnt_in = CW'(1); end
               8'h3e: begin mode_in = MODE_GT; buf_in = {56'd0, c}; cnt_in = CW'(1); end
               8'h3a: begin mode_in = MODE_COLON; buf_in = {56'd0, c}; cnt_in = CW'(1); end
               8'h2a, 8'h2f, 8'h2b, 8'h2d, 8'h3d, 8'h28, 8'h29: begin
                  own_v = 1'b1; own.kind = KIND_OPER;
               end
               8'h3b, 8'h2c, 8'h2e: begin own_v = 1'b1; own.kind = KIND_SEP; end
               8'h23: begin own_v = 1'b1; own.kind = KIND_END; end
               8'h20: ;
               8'h0a: if (line_ff != 16'hffff) line_in = line_ff + 16'd1;
               default: own_v = 1'b1;
            endcase
         end
      end else if (mode_in == MODE_IDLE) begin
         buf_in = 64'd0; cnt_in = '0;
      end
      emit = step && (pend_v || own_v);
      pair.two = pend_v && own_v;
      pair.t0 = pend_v ? pend : own;
      pair.t1 = own;
      if (pend_v && own_v) pair.t1.last = 1'b1;
      else pair.t0.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; buf_ff <= 64'd0; cnt_ff <= '0; acc_ff <= 17'd0;
         line_ff <= 16'd1;
      end else if (step) begin
         mode_ff <= mode_in; buf_ff <= buf_in; cnt_ff <= cnt_in; acc_ff <= acc_in;
         line_ff <= line_in;
      end
   end
endmodule

/* hdl/kwlex_back.sv */
// ----------------------------------------------------------------------------
// kwlex_back
// two-entry queue of token pairs, issues one token per pop
// ----------------------------------------------------------------------------
module kwlex_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr,
   input  kwlex_pkg::pair_type  wdata,
   output logic                 full,
   output logic                 empty,
   input  logic                 pop,
   output kwlex_pkg::token_type tok
);
   import kwlex_pkg::*;

   pair_type q_ff [2];
   logic rp_ff, wp_ff, half_ff;
   logic [1:0] cnt_ff;
   logic rd;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign tok = half_ff ? q_ff[rp_ff].t1 : q_ff[rp_ff].t0;
   assign rd = pop && !empty && (half_ff || !q_ff[rp_ff].two);

   always_ff @(posedge clock) begin
      if (wr) q_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff <= 1'b0; wp_ff <= 1'b0; half_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (pop && !empty) begin
            half_ff <= !rd;
            if (rd) rp_ff <= !rp_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for keyword_lexer: characters are pushed from a queue,
// tokens are predicted on acceptance and compared field by field on pop
// ----------------------------------------------------------------------------
module tb;
   import kwlex_pkg::*;

   localparam int MAXT      = 8;
   localparam int IDLE_STOP = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [7:0]  req_char_code = 8'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [63:0] rsp_token_text;
   logic [3:0]  rsp_text_length;
   logic [15:0] rsp_number_value;
   logic [15:0] rsp_line_number;
   logic        rsp_last_of_run;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;

   keyword_lexer DUT (.*);

   always #6 clock = ~clock;

   // predictor state
   logic [15:0] lim_q;
   mode_type    mode_q;
   logic [63:0] buf_q;
   logic [3:0]  cnt_q;
   logic [16:0] acc_q;
   logic [15:0] line_q;

   token_type   tok_due[$];
   logic [7:0]  char_pend[$];
   int          errors = 0;
   int          tokens_seen = 0;
   int          chars_sent = 0;
   int          idle_cycles = 0;
   bit          feed_hold = 1'b0;
   int          send_gap = 0;
   int          pop_gap = 0;

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_num(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic add_token(logic [2:0] k, logic [63:0] t, logic [3:0] l, logic [15:0] v);
      token_type tk;
      tk.kind = k; tk.text = t; tk.len = l; tk.value = v; tk.line = line_q; tk.last = 1'b0;
      tok_due.push_back(tk);
   endtask

   // is the buffered name one of the six keywords
   function automatic bit keyword_hit(logic [63:0] b, logic [3:0] l);
      case (l)
         4'd2: return b[15:0] == "fi" || b[15:0] == "od";
         4'd3: return b[23:0] == "dne";
         4'd4: return b[31:0] == "neht";
         4'd5: return b[39:0] == "nigeb" || b[39:0] == "elihw";
         default: return 1'b0;
      endcase
   endfunction

   task automatic start_fresh(logic [7:0] c);
      mode_q = MODE_IDLE; buf_q = '0; cnt_q = '0; acc_q = '0;
      if (is_alpha(c)) begin
         mode_q = MODE_NAME; buf_q = {56'd0, c}; cnt_q = 4'd1;
      end else if (is_num(c)) begin
         mode_q = MODE_NUM; acc_q = {9'd0, c} - 17'd48;
      end else begin
         case (c)
            "<": begin mode_q = MODE_LT; buf_q = {56'd0, c}; cnt_q = 4'd1; end
            ">": begin mode_q = MODE_GT; buf_q = {56'd0, c}; cnt_q = 4'd1; end
            ":": begin mode_q = MODE_COLON; buf_q = {56'd0, c}; cnt_q = 4'd1; end
            "*", "/", "+", "-", "=", "(", ")": add_token(KIND_OPER, {56'd0, c}, 4'd1, 16'd0);
            ";", ",", ".": add_token(KIND_SEP, {56'd0, c}, 4'd1, 16'd0);
            "#": add_token(KIND_END, {56'd0, c}, 4'd1, 16'd0);
            " ": ;
            8'h0a: if (line_q != 16'hffff) line_q = line_q + 16'd1;
            default: add_token(KIND_ERROR, {56'd0, c}, 4'd1, 16'd0);
         endcase
      end
   endtask

   // work out the tokens one accepted character causes
   task automatic lex_char(logic [7:0] c);
      int     base_size;
      bit     fresh;
      logic [3:0]  l;
      logic [20:0] v;
      base_size = tok_due.size();
      fresh = 1'b1;
      case (mode_q)
         MODE_NAME: begin
            if (is_alpha(c) || is_num(c)) begin
               if (cnt_q < MAXT) begin
                  buf_q = buf_q | ({56'd0, c} << (8 * cnt_q));
                  cnt_q = cnt_q + 4'd1;
               end else cnt_q = 4'(MAXT + 1);
               fresh = 1'b0;
            end else begin
               // over-long names are cut to eight and never keywords
               l = (cnt_q > MAXT) ? 4'(MAXT) : cnt_q;
               add_token((cnt_q <= MAXT && keyword_hit(buf_q, l)) ? KIND_KEYWORD : KIND_IDENT,
                         buf_q, l, 16'd0);
            end
         end
         MODE_NUM: begin
            if (is_num(c)) begin
               v = 21'(acc_q * 10 + (c - 8'd48));
               acc_q = (v > 21'(ACC_SAT)) ? ACC_SAT : v[16:0];
               fresh = 1'b0;
            end else if (acc_q > {1'b0, lim_q}) add_token(KIND_ERROR, '0, 4'd0, 16'd0);
            else add_token(KIND_NUMBER, '0, 4'd0, acc_q[15:0]);
         end
         MODE_LT, MODE_GT, MODE_COLON: begin
            if (c == "=" || (mode_q == MODE_LT && c == ">")) begin
               add_token(KIND_OPER, buf_q | ({56'd0, c} << 8), 4'd2, 16'd0);
               fresh = 1'b0;
               mode_q = MODE_IDLE;
            end else add_token(KIND_OPER, buf_q, 4'd1, 16'd0);
         end
         default: ;
      endcase
      if (fresh) start_fresh(c);
      else if (mode_q == MODE_IDLE) begin
         buf_q = '0; cnt_q = '0;
      end
      if (tok_due.size() > base_size) tok_due[tok_due.size() - 1].last = 1'b1;
   endtask

   // driver: one character per push, random gaps
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            lex_char(req_char_code);
            chars_sent <= chars_sent + 1;
         end
         if (push && full) ;
         else if (!feed_hold && send_gap == 0 && char_pend.size() > 0) begin
            push <= 1'b1;
            req_char_code <= char_pend.pop_front();
            send_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                        ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3));
         end else begin
            push <= 1'b0;
            if (send_gap > 0) send_gap <= send_gap - 1;
         end
      end
   end

   // monitor: random pop, compare each token with the oldest prediction
   always @(posedge clock) begin
      token_type ex;
      if (!reset) begin
         if (pop && !empty) begin
            tokens_seen <= tokens_seen + 1;
            if (tok_due.size() == 0) begin
               $error("token with nothing predicted, kind %0d", rsp_token_kind);
               errors = errors + 1;
            end else begin
               ex = tok_due.pop_front();
               if (rsp_token_kind !== ex.kind) begin
                  $error("token_kind expected %0d got %0d", ex.kind, rsp_token_kind);
                  errors = errors + 1;
               end
               if (rsp_token_text !== ex.text) begin
                  $error("token_text expected %h got %h", ex.text, rsp_token_text);
                  errors = errors + 1;
               end
               if (rsp_text_length !== ex.len) begin
                  $error("text_length expected %0d got %0d", ex.len, rsp_text_length);
                  errors = errors + 1;
               end
               if (rsp_number_value !== ex.value) begin
                  $error("number_value expected %0d got %0d", ex.value, rsp_number_value);
                  errors = errors + 1;
               end
               if (rsp_line_number !== ex.line) begin
                  $error("line_number expected %0d got %0d", ex.line, rsp_line_number);
                  errors = errors + 1;
               end
               if (rsp_last_of_run !== ex.last) begin
                  $error("last_of_run expected %0d got %0d", ex.last, rsp_last_of_run);
                  errors = errors + 1;
               end
            end
         end
         if (pop_gap > 0) begin
            pop <= 1'b0;
            pop_gap <= pop_gap - 1;
         end else begin
            pop <= 1'b1;
            pop_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                       ($urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3));
         end
      end
   end

   // watchdog: cycles with no accepted item on either side
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_STOP) begin
         $display("keyword_lexer verification failed");
         $finish;
      end
   end

   task automatic add_word(string s);
      foreach (s[i]) char_pend.push_back(s[i]);
   endtask

   // wait until every queued character is in and every token is out
   task automatic drain();
      @(negedge clock);
      while (char_pend.size() > 0 || push || tok_due.size() > 0) @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_limit(logic [15:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lim_q = v;
   endtask

   // random source text: mostly plausible tokens, some raw noise
   task automatic add_random_text(int n);
      string kw[6] = '{"begin", "if", "then", "while", "do", "end"};
      string op[14] = '{"+", "-", "*", "/", "=", "(", ")", "<", ">", ":", "<>", "<=", ">=",
                        ":="};
      string sep = ";,.";
      int    target;
      int    r;
      int    k;
      target = char_pend.size() + n;
      while (char_pend.size() < target) begin
         r = $urandom_range(0, 99);
         if (r < 20) add_word(kw[$urandom_range(0, 5)]);
         else if (r < 40) begin
            k = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 14 : 6);
            repeat (k) begin
               case ($urandom_range(0, 2))
                  0: char_pend.push_back(8'($urandom_range(97, 122)));
                  1: char_pend.push_back(8'($urandom_range(65, 90)));
                  default: char_pend.push_back(8'($urandom_range(48, 57)));
               endcase
            end
         end else if (r < 55) begin
            k = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 7 : 4);
            repeat (k) char_pend.push_back(8'($urandom_range(48, 57)));
         end else if (r < 70) add_word(op[$urandom_range(0, 13)]);
         else if (r < 76) char_pend.push_back(sep[$urandom_range(0, 2)]);
         else if (r < 88) char_pend.push_back(" ");
         else if (r < 92) char_pend.push_back(8'h0a);
         else if (r < 94) char_pend.push_back("#");
         else char_pend.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      lim_q = LIMIT_RESET; mode_q = MODE_IDLE; buf_q = '0; cnt_q = '0; acc_q = '0;
      line_q = 16'd1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: keywords, near misses, long names, every operator, extremes
      add_word("begin if then while do end Begin iff ends ");
      add_word("abcdefgh abcdefghi beginning1 x9;");
      add_word("+-*/=()<><=>=:=< > :a;,.#");
      add_word("0 32767 32768 99999999 7\n");
      char_pend.push_back(8'h09);
      char_pend.push_back(8'h0d);
      char_pend.push_back(8'hff);
      char_pend.push_back(8'h80);
      char_pend.push_back(8'h00);
      char_pend.push_back(8'h7f);
      add_word("\n");
      drain();

      set_limit(16'd0);
      add_word("0 1 00 ");
      add_random_text(400);
      // part way through, hold the feed until every predicted token has been popped
      repeat (300) @(negedge clock);
      feed_hold = 1'b1;
      @(negedge clock);
      while (push || tok_due.size() > 0) @(negedge clock);
      feed_hold = 1'b0;
      drain();

      set_limit(16'hffff);
      add_word("65535 65536 655350 ");
      add_random_text(400);
      drain();

      set_limit(16'd500);
      add_random_text(400);
      drain();

      set_limit(16'd12345);
      add_random_text(400);
      // lots of newlines to move the line counter a long way
      repeat (300) char_pend.push_back(8'h0a);
      add_word("x ");
      drain();

      $display("sent %0d characters, checked %0d tokens over five number limits",
               chars_sent, tokens_seen);
      if (errors == 0) $display("keyword_lexer verification clean");
      else $display("keyword_lexer verification failed");
      $finish;
   end
endmodule

/* sim.f */
+incdir+hdl
hdl/kwlex_pkg.sv
hdl/kwlex_front.sv
hdl/kwlex_back.sv
hdl/keyword_lexer.sv
sim/tb.sv
